FILE: rtl/hkc_pkg.sv
// Package for the hotkey chord edge detector: shared constants, command codes
// and the packed payload types of the item and result channels.
// No dependencies.
package hkc_pkg;

  // Default sizes, handed to the top level's parameters
  localparam int HOTKEY_SLOTS_DEF   = 8;
  localparam int KEYS_PER_COMBO_DEF = 4;
  localparam int KEY_CODES_DEF      = 256;

  // Fixed field widths
  localparam int CODE_W      = 8;
  localparam int MASK_W      = 8;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 32;

  // Command codes
  localparam logic [1:0] CMD_KEY  = 2'd0;
  localparam logic [1:0] CMD_SCAN = 2'd1;
  localparam logic [1:0] CMD_FLIP = 2'd2;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [CODE_W-1:0] key_code;
    logic              key_down;
    logic [2:0]        slot;
  } in_t;

  typedef struct packed {
    logic [MASK_W-1:0] held_mask;
    logic [MASK_W-1:0] toggle_mask;
    logic [MASK_W-1:0] changed_mask;
  } out_t;

  typedef enum logic {
    CFG_IDLE,
    CFG_REFRESH
  } cfg_state_t;

endpackage

FILE: rtl/hotkey_chord_edge_detector_unit.sv
// Hotkey chord edge detector, top level: key map, per-slot combo registers,
// scan logic and a two-entry result queue. Depends on hkc_pkg.
//
// Usage:
//  - Item channel (in_valid/in_ready/in_data) takes key events, scans and
//    toggle flips. Result channel (out_valid/out_ready/out_data) returns the
//    held, toggle and changed masks as they stand after each item.
//  - Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes a
//    slot's combo; an index at or above HOTKEY_SLOTS is ignored. Each slot write
//    is followed by a reload of the slot's per-byte key-down bits from the key
//    map, one byte a cycle; items and further writes are held off meanwhile.
//  - Throughput: one item per cycle while no reload runs and the queue has
//    room. Every slot compares its combo bytes against each key event in
//    parallel, so a scan is a single AND per slot.
//  - The two-entry result queue registers each result as its item transfers;
//    a stalled receiver costs nothing until the queue fills.
//  - Reset (rst, synchronous) clears the key map, all slot state and the combo
//    registers and empties the result queue; no clearing pass follows.
module hotkey_chord_edge_detector_unit #(
  parameter int HOTKEY_SLOTS   = hkc_pkg::HOTKEY_SLOTS_DEF,
  parameter int KEYS_PER_COMBO = hkc_pkg::KEYS_PER_COMBO_DEF,
  parameter int KEY_CODES      = hkc_pkg::KEY_CODES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  hkc_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output hkc_pkg::out_t                  out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [hkc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [hkc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import hkc_pkg::*;

  localparam int KEY_W  = $clog2(KEY_CODES);
  localparam int BYTE_W = (KEYS_PER_COMBO > 1) ? $clog2(KEYS_PER_COMBO) : 1;
  localparam int SLOT_W = (HOTKEY_SLOTS > 1) ? $clog2(HOTKEY_SLOTS) : 1;

  // Combo registers and per-byte key-down bits
  logic [CODE_W-1:0]         combo_key [HOTKEY_SLOTS][KEYS_PER_COMBO];
  logic [KEYS_PER_COMBO-1:0] combo_down [HOTKEY_SLOTS];
  logic [KEY_CODES-1:0]      key_map;

  logic [HOTKEY_SLOTS-1:0] slot_held, slot_held_next;
  logic [HOTKEY_SLOTS-1:0] slot_toggle, slot_toggle_next;
  logic [HOTKEY_SLOTS-1:0] slot_changed, slot_changed_next;
  logic [HOTKEY_SLOTS-1:0] held_now;

  cfg_state_t        cfg_state, cfg_state_next;
  logic [SLOT_W-1:0] ref_slot;
  logic [BYTE_W-1:0] ref_byte;
  logic [CODE_W-1:0] ref_code;
  logic              ref_down;
  logic              busy;

  logic in_xfer, cfg_xfer, cfg_hit, key_ok;

  // Result queue
  out_t       res;
  out_t       fifo [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] fifo_cnt;
  logic       out_xfer;

  function automatic logic code_ok(input logic [CODE_W-1:0] code);
    return (code != '0) && ({1'b0, code} < (CODE_W + 1)'(KEY_CODES));
  endfunction

  assign in_xfer  = in_valid && in_ready;
  assign cfg_xfer = cfg_valid && cfg_ready;
  assign cfg_hit  = cfg_xfer && (32'(cfg_index) < 32'(HOTKEY_SLOTS));
  assign out_xfer = out_valid && out_ready;
  assign key_ok   = code_ok(in_data.key_code);

  // Refresh sequencer: next state
  always_comb begin
    cfg_state_next = cfg_state;
    unique case (cfg_state)
      CFG_IDLE: begin
        if (cfg_hit) cfg_state_next = CFG_REFRESH;
      end
      CFG_REFRESH: begin
        if (ref_byte == BYTE_W'(KEYS_PER_COMBO - 1)) cfg_state_next = CFG_IDLE;
      end
      default: cfg_state_next = CFG_IDLE;
    endcase
  end

  // Refresh sequencer: outputs
  always_comb begin
    busy = (cfg_state == CFG_REFRESH);
    cfg_ready = !busy;
    in_ready  = !busy && (fifo_cnt != 2'd2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_state <= CFG_IDLE;
      ref_slot  <= '0;
      ref_byte  <= '0;
    end else begin
      cfg_state <= cfg_state_next;
      if (cfg_hit) begin
        ref_slot <= cfg_index[SLOT_W-1:0];
        ref_byte <= '0;
      end else if (busy) begin
        ref_byte <= ref_byte + 1'b1;
      end
    end
  end

  assign ref_code = combo_key[ref_slot][ref_byte];
  assign ref_down = code_ok(ref_code) && key_map[ref_code[KEY_W-1:0]];

  // Combo registers, key map and per-byte key-down bits
  always_ff @(posedge clk) begin
    if (rst) begin
      key_map <= '0;
      for (int s = 0; s < HOTKEY_SLOTS; s++) begin
        combo_down[s] <= '0;
        for (int i = 0; i < KEYS_PER_COMBO; i++) combo_key[s][i] <= '0;
      end
    end else begin
      if (cfg_hit) begin
        for (int i = 0; i < KEYS_PER_COMBO; i++) begin
          combo_key[cfg_index[SLOT_W-1:0]][i] <= cfg_data[CODE_W*i +: CODE_W];
        end
      end
      if (busy) begin
        combo_down[ref_slot][ref_byte] <= ref_down;
      end else if (in_xfer && (in_data.cmd == CMD_KEY) && key_ok) begin
        key_map[in_data.key_code[KEY_W-1:0]] <= in_data.key_down;
        for (int s = 0; s < HOTKEY_SLOTS; s++) begin
          for (int i = 0; i < KEYS_PER_COMBO; i++) begin
            if (combo_key[s][i] == in_data.key_code) combo_down[s][i] <= in_data.key_down;
          end
        end
      end
    end
  end

  // Held rule: byte 0 always tested, higher bytes only up to the top non-zero byte
  always_comb begin
    logic tail_zero;
    logic ok;
    for (int s = 0; s < HOTKEY_SLOTS; s++) begin
      tail_zero = 1'b1;
      ok        = 1'b1;
      for (int i = KEYS_PER_COMBO - 1; i >= 0; i--) begin
        tail_zero = tail_zero && (combo_key[s][i] == '0);
        ok = ok && (combo_down[s][i] || ((i != 0) && tail_zero));
      end
      held_now[s] = ok;
    end
  end

  always_comb begin
    slot_held_next    = slot_held;
    slot_toggle_next  = slot_toggle;
    slot_changed_next = slot_changed;
    if (in_xfer) begin
      unique case (in_data.cmd)
        CMD_SCAN: begin
          slot_held_next    = held_now;
          slot_changed_next = held_now ^ slot_held;
          slot_toggle_next  = slot_toggle ^ (held_now & ~slot_held);
        end
        CMD_FLIP: begin
          if (32'(in_data.slot) < 32'(HOTKEY_SLOTS)) begin
            slot_toggle_next[in_data.slot[SLOT_W-1:0]] =
              !slot_toggle[in_data.slot[SLOT_W-1:0]];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_held    <= '0;
      slot_toggle  <= '0;
      slot_changed <= '0;
    end else begin
      slot_held    <= slot_held_next;
      slot_toggle  <= slot_toggle_next;
      slot_changed <= slot_changed_next;
    end
  end

  always_comb begin
    res.held_mask    = MASK_W'(slot_held_next);
    res.toggle_mask  = MASK_W'(slot_toggle_next);
    res.changed_mask = MASK_W'(slot_changed_next);
  end

  // Two-entry result queue: hold results while the receiver stalls
  always_ff @(posedge clk) begin
    if (in_xfer) fifo[wr_ptr] <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= 1'b0;
      rd_ptr   <= 1'b0;
      fifo_cnt <= 2'd0;
    end else begin
      if (in_xfer)  wr_ptr <= !wr_ptr;
      if (out_xfer) rd_ptr <= !rd_ptr;
      if (in_xfer && !out_xfer)      fifo_cnt <= fifo_cnt + 2'd1;
      else if (!in_xfer && out_xfer) fifo_cnt <= fifo_cnt - 2'd1;
    end
  end

  assign out_valid = (fifo_cnt != 2'd0);
  assign out_data  = fifo[rd_ptr];

endmodule

FILE: rtl/hkc_checker.sv
// Port-level checks for the hotkey chord edge detector, bound to the top
// level. Depends on hkc_pkg and hotkey_chord_edge_detector_unit.
module hkc_checker #(
  parameter int HOTKEY_SLOTS = hkc_pkg::HOTKEY_SLOTS_DEF
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input hkc_pkg::out_t                   out_data,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic [hkc_pkg::CFG_INDEX_W-1:0] cfg_index
);
  import hkc_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Slots beyond the configured count never show a bit
  a_unused_slots: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_data.held_mask >> HOTKEY_SLOTS) == '0) &&
                  ((out_data.toggle_mask >> HOTKEY_SLOTS) == '0) &&
                  ((out_data.changed_mask >> HOTKEY_SLOTS) == '0))
    else $error("mask bit set for an absent slot");

  // Reset empties the result queue
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered straight after reset");

  // A combo write blocks both channels while the slot is reloaded
  a_refresh_blocks: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready && (32'(cfg_index) < 32'(HOTKEY_SLOTS))
      |=> !in_ready && !cfg_ready)
    else $error("channel open during slot reload");

endmodule

bind hotkey_chord_edge_detector_unit hkc_checker #(
  .HOTKEY_SLOTS(HOTKEY_SLOTS)
) u_hkc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready),
  .cfg_index (cfg_index)
);

FILE: sim/hotkey_chord_edge_detector_unit_test.sv
`timescale 1ns / 1ps
// Self-checking bench for hotkey_chord_edge_detector_unit: a directed table, then
// random phases of key traffic checked against a behavioural copy of the key map
// and slot masks. Depends on hkc_pkg and the RTL top level.
module hotkey_chord_edge_detector_unit_test;
  import hkc_pkg::*;

  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int SLOTS            = HOTKEY_SLOTS_DEF;
  localparam int CHORD_KEYS       = 6;
  localparam int PRE_CFG_ROWS     = 8;
  localparam int SCRIPT_ROWS      = 25;
  localparam int PHASES           = 7;
  localparam int PHASE_ITEMS      = 170;
  localparam int QUIET_ITEMS      = 150;
  localparam int LONG_HOLD_AT     = 400;
  localparam int LONG_HOLD_CYCLES = 80;
  localparam int REPORT_LIMIT     = 10;

  typedef struct {
    in_t  item;
    bit   typed;
    out_t want;
  } script_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  in_t                    in_data = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_t                   out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Behavioural copy of the block
  logic [KEY_CODES_DEF-1:0] keys_down;
  logic [CFG_DATA_W-1:0]    combo [SLOTS];
  logic [MASK_W-1:0]        held, toggle, changed;

  out_t       masks_due [$];
  logic [7:0] chord_keys [CHORD_KEYS];
  int         mismatches = 0;
  int         results_seen = 0;
  bit         quiet = 1'b0;
  bit         hold_active = 1'b0;
  bit         long_hold_done = 1'b0;

  logic [CFG_DATA_W-1:0] demo_chords [SLOTS] = '{
    32'h0000_0041, 32'h0000_4241, 32'h4342_0041, 32'h0000_00FF,
    32'hFFFF_FFFF, 32'h0000_4241, 32'h0000_0000, 32'h0000_0001
  };

  // Rows before PRE_CFG_ROWS run with every slot empty, so their masks are typed in
  script_row_t script [SCRIPT_ROWS] = '{
    '{'{CMD_KEY,  8'h00, 1'b1, 3'd7}, 1'b1, '{8'h00, 8'h00, 8'h00}},
    '{'{CMD_SCAN, 8'h00, 1'b0, 3'd0}, 1'b1, '{8'h00, 8'h00, 8'h00}},
    '{'{CMD_FLIP, 8'h00, 1'b0, 3'd0}, 1'b1, '{8'h00, 8'h01, 8'h00}},
    '{'{CMD_FLIP, 8'hFF, 1'b1, 3'd7}, 1'b1, '{8'h00, 8'h81, 8'h00}},
    '{'{CMD_NONE, 8'hFF, 1'b1, 3'd7}, 1'b1, '{8'h00, 8'h81, 8'h00}},
    '{'{CMD_FLIP, 8'h00, 1'b0, 3'd0}, 1'b1, '{8'h00, 8'h80, 8'h00}},
    '{'{CMD_FLIP, 8'h00, 1'b0, 3'd7}, 1'b1, '{8'h00, 8'h00, 8'h00}},
    '{'{CMD_KEY,  8'hFF, 1'b1, 3'd0}, 1'b1, '{8'h00, 8'h00, 8'h00}},
    '{'{CMD_SCAN, 8'h00, 1'b0, 3'd0}, 1'b0, '0},
    '{'{CMD_KEY,  8'h41, 1'b1, 3'd0}, 1'b0, '0},
    '{'{CMD_SCAN, 8'h00, 1'b0, 3'd0}, 1'b0, '0},
    '{'{CMD_SCAN, 8'hFF, 1'b1, 3'd7}, 1'b0, '0},
    '{'{CMD_KEY,  8'h42, 1'b1, 3'd0}, 1'b0, '0},
    '{'{CMD_SCAN, 8'h00, 1'b0, 3'd0}, 1'b0, '0},
    '{'{CMD_KEY,  8'h43, 1'b1, 3'd0}, 1'b0, '0},
    '{'{CMD_SCAN, 8'h00, 1'b0, 3'd0}, 1'b0, '0},
    '{'{CMD_KEY,  8'h01, 1'b1, 3'd0}, 1'b0, '0},
    '{'{CMD_KEY,  8'h00, 1'b0, 3'd0}, 1'b0, '0},
    '{'{CMD_SCAN, 8'h00, 1'b0, 3'd0}, 1'b0, '0},
    '{'{CMD_FLIP, 8'h00, 1'b0, 3'd3}, 1'b0, '0},
    '{'{CMD_KEY,  8'h41, 1'b0, 3'd0}, 1'b0, '0},
    '{'{CMD_SCAN, 8'h00, 1'b0, 3'd0}, 1'b0, '0},
    '{'{CMD_KEY,  8'hFF, 1'b0, 3'd0}, 1'b0, '0},
    '{'{CMD_SCAN, 8'h00, 1'b0, 3'd0}, 1'b0, '0},
    '{'{CMD_NONE, 8'h00, 1'b0, 3'd0}, 1'b0, '0}
  };

  hotkey_chord_edge_detector_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Byte 0 always counts; every byte up to the highest non-zero one must be down
  function automatic bit chord_held(input logic [CFG_DATA_W-1:0] c);
    int top;
    top = 0;
    if (c == '0) return 1'b0;
    for (int i = 0; i < KEYS_PER_COMBO_DEF; i++)
      if (c[8*i +: 8] != 8'h00) top = i;
    for (int i = 0; i <= top; i++)
      if (!keys_down[c[8*i +: 8]]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic out_t next_masks(input in_t it);
    bit now;
    case (it.cmd)
      CMD_KEY: begin
        if (it.key_code != 8'h00) keys_down[it.key_code] = it.key_down;
      end
      CMD_SCAN: begin
        for (int s = 0; s < SLOTS; s++) begin
          now = chord_held(combo[s]);
          if (now != held[s]) begin
            changed[s] = 1'b1;
            held[s]    = now;
            if (now) toggle[s] = ~toggle[s];
          end else begin
            changed[s] = 1'b0;
          end
        end
      end
      CMD_FLIP: begin
        toggle[it.slot] = ~toggle[it.slot];
      end
      default: ;
    endcase
    return '{held_mask: held, toggle_mask: toggle, changed_mask: changed};
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_combo();
    logic [CFG_DATA_W-1:0] c;
    int n;
    c = '0;
    case ($urandom_range(19))
      0: return '0;
      1: return '1;
      2: return $urandom;
      // zero bytes below a set byte: never held
      3: return {chord_keys[$urandom_range(CHORD_KEYS-1)], 16'h0000,
                 chord_keys[$urandom_range(CHORD_KEYS-1)]};
      default: begin
        n = $urandom_range(1, KEYS_PER_COMBO_DEF);
        for (int i = 0; i < n; i++) c[8*i +: 8] = chord_keys[$urandom_range(CHORD_KEYS-1)];
        return c;
      end
    endcase
  endfunction

  // Mostly key events, largely on the chord keys, with scans; unused fields stay random
  function automatic in_t pick_item();
    logic [31:0] raw;
    in_t it;
    int r;
    raw = $urandom;
    it  = raw[$bits(in_t)-1:0];
    r   = $urandom_range(99);
    if (r < 45) begin
      it.cmd      = CMD_KEY;
      it.key_code = chord_keys[$urandom_range(CHORD_KEYS-1)];
    end else if (r < 55) begin
      it.cmd = CMD_KEY;
    end else if (r < 85) begin
      it.cmd = CMD_SCAN;
    end else if (r < 95) begin
      it.cmd = CMD_FLIP;
    end else begin
      it.cmd = CMD_NONE;
    end
    return it;
  endfunction

  task automatic send_item(input in_t it, input bit typed, input out_t want);
    out_t predicted;
    in_valid = 1'b1;
    in_data  = it;
    do @(posedge clk); while (!in_ready);
    predicted = next_masks(it);
    masks_due.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  task automatic maybe_pause(input int pct);
    if (!quiet && !hold_active && $urandom_range(99) < pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
  endtask

  // Hold off until every expected result has come back
  task automatic drain();
    in_valid = 1'b0;
    while (masks_due.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    if (idx < SLOTS) combo[idx] = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  initial begin
    int pause_pct;
    keys_down = '0;
    held      = '0;
    toggle    = '0;
    changed   = '0;
    for (int s = 0; s < SLOTS; s++) combo[s] = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int r = 0; r < SCRIPT_ROWS; r++) begin
      if (r == PRE_CFG_ROWS) begin
        drain();
        for (int s = 0; s < SLOTS; s++) write_reg(CFG_INDEX_W'(s), demo_chords[s]);
        // out-of-range indexes must not alias onto a slot
        write_reg(CFG_INDEX_W'(SLOTS), 32'hFFFF_FFFF);
        write_reg('1, 32'h0000_00FF);
      end
      maybe_pause(10);
      send_item(script[r].item, script[r].typed, script[r].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      drain();
      for (int k = 0; k < CHORD_KEYS; k++) chord_keys[k] = 8'($urandom_range(1, 255));
      if (p == 0) chord_keys[0] = 8'hFF;
      for (int s = 0; s < SLOTS; s++)
        write_reg(CFG_INDEX_W'(s), p == 0 ? '1 : p == 1 ? '0 : pick_combo());
      write_reg(CFG_INDEX_W'(SLOTS + $urandom_range(SLOTS - 1)), $urandom);
      pause_pct = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 10 : 35;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == PHASES - 1 && n >= PHASE_ITEMS - QUIET_ITEMS) quiet = 1'b1;
        maybe_pause(pause_pct);
        send_item(pick_item(), 1'b0, '0);
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Result side: random stalls, and one long hold to fill the block up
  initial begin
    int stall_pct;
    int cycles;
    stall_pct = 0;
    cycles    = 0;
    wait (!rst);
    forever begin
      @(negedge clk);
      cycles++;
      if (cycles % 100 == 0) stall_pct = $urandom_range(2) * 15;
      if (!quiet && !long_hold_done && results_seen >= LONG_HOLD_AT) begin
        out_ready   = 1'b0;
        hold_active = 1'b1;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        hold_active    = 1'b0;
        long_hold_done = 1'b1;
      end else if (!quiet && $urandom_range(99) < stall_pct) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end
      out_ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (masks_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: result %h arrived with nothing expected", $realtime, out_data);
      end else begin
        want = masks_due.pop_front();
        if (out_data.held_mask !== want.held_mask ||
            out_data.toggle_mask !== want.toggle_mask ||
            out_data.changed_mask !== want.changed_mask) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: held exp %h got %h, toggle exp %h got %h, changed exp %h got %h",
                     $realtime, want.held_mask, out_data.held_mask, want.toggle_mask,
                     out_data.toggle_mask, want.changed_mask, out_data.changed_mask);
        end
      end
    end
  end

  initial begin
    #(20_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
